FILE: rtl/nrle_pkg.sv
// Shared types for the number range list encoder.
package nrle_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_PLAIN   = 3'd1,
		MODE_PEND_UP = 3'd2,
		MODE_PEND_DN = 3'd3,
		MODE_RUN_UP  = 3'd4,
		MODE_RUN_DN  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_FIRST = 2'd0,
		KIND_COMMA = 2'd1,
		KIND_DASH  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  list_end;
	} tag_t;

endpackage

FILE: rtl/number_range_list_encoder.sv
// Number range list encoder top level: input register, run state, result register.
// Takes one number per beat unless stalled by a busy result register, and emits range tokens
// (first, comma, dash-run-end). An item goes from the input register through the token
// logic into a two-slot result register, which then offers the item's first token. An item
// yielding two tokens (a flushed run or pending number plus the new number or its end-of-list
// flush) holds the result register until both are taken, since the result port delivers one
// token per beat while token_ready is high. add_one must be written only while idle.
module number_range_list_encoder import nrle_pkg::*; #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                 last_item,
	output logic                 token_valid,
	input  logic                 token_ready,
	output logic [1:0]           token_kind,
	output logic [VALUE_WIDTH:0] token_number,
	output logic                 list_end
);

	logic                   add_one_q;
	logic                   valid_s1;
	logic [VALUE_WIDTH-1:0] value_s1;
	logic                   last_s1;
	mode_t                  mode_q;
	logic [VALUE_WIDTH-1:0] prev_q;

	mode_t                      mode_nxt;
	logic [VALUE_WIDTH-1:0]     prev_nxt;
	logic [1:0]                 count;
	tag_t [1:0]                 tags;
	logic [1:0][VALUE_WIDTH:0]  nums;
	logic                       free;
	logic                       advance;
	tag_t                       head_tag;

	assign advance    = valid_s1 && free;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_one_q <= 1'b0;
		end else if (cfg_wr_en) begin
			add_one_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			value_s1 <= value;
			last_s1  <= last_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			prev_q <= '0;
		end else if (advance) begin
			mode_q <= mode_nxt;
			prev_q <= prev_nxt;
		end
	end

	nrle_encode #(.W(VALUE_WIDTH)) u_encode (
		.mode      (mode_q),
		.prev      (prev_q),
		.value     (value_s1),
		.last_item (last_s1),
		.add_one   (add_one_q),
		.mode_nxt  (mode_nxt),
		.prev_nxt  (prev_nxt),
		.count     (count),
		.tags      (tags),
		.nums      (nums)
	);

	nrle_obuf #(.W(VALUE_WIDTH)) u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.load_count  (count),
		.load_tags   (tags),
		.load_nums   (nums),
		.free        (free),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.head_tag    (head_tag),
		.head_num    (token_number)
	);

	assign token_kind = head_tag.kind;
	assign list_end   = head_tag.list_end;

	a_idle_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> mode_q == MODE_IDLE)
		else $error("mode not idle after list end");

	a_first_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_q == MODE_IDLE) |-> (count != 2'd0 && tags[0].kind == KIND_FIRST))
		else $error("list start without first token");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !free) |=> (valid_s1 && $stable(value_s1) && $stable(mode_q)))
		else $error("input stage changed while stalled");

endmodule

FILE: rtl/nrle_encode.sv
// Combinational token builder: next mode, held number and up to two tokens per item.
module nrle_encode import nrle_pkg::*; #(
	parameter int W = 16
) (
	input  mode_t               mode,
	input  logic [W-1:0]        prev,
	input  logic [W-1:0]        value,
	input  logic                last_item,
	input  logic                add_one,
	output mode_t               mode_nxt,
	output logic [W-1:0]        prev_nxt,
	output logic [1:0]          count,
	output tag_t [1:0]          tags,
	output logic [1:0][W:0]     nums
);

	logic         up;
	logic         dn;
	logic         plain;
	logic [1:0]   n;
	logic [1:0]   idx;
	logic [1:0][W-1:0] raw;

	// exact difference of +1 / -1, one extra bit so no wrap
	assign up = {1'b0, value} == ({1'b0, prev} + {{W{1'b0}}, 1'b1});
	assign dn = ({1'b0, value} + {{W{1'b0}}, 1'b1}) == {1'b0, prev};

	always_comb begin
		tags     = '0;
		raw      = '0;
		n        = 2'd0;
		idx      = 2'd0;
		mode_nxt = mode;
		prev_nxt = prev;
		plain    = 1'b0;
		case (mode)
			MODE_PLAIN: begin
				plain = 1'b1;
			end
			MODE_PEND_UP, MODE_PEND_DN: begin
				if ((mode == MODE_PEND_UP && up) || (mode == MODE_PEND_DN && dn)) begin
					mode_nxt = (mode == MODE_PEND_UP) ? MODE_RUN_UP : MODE_RUN_DN;
					prev_nxt = value;
				end else begin
					tags[0].kind = KIND_COMMA;
					raw[0]       = prev;
					n            = 2'd1;
					plain        = 1'b1;
				end
			end
			MODE_RUN_UP, MODE_RUN_DN: begin
				if ((mode == MODE_RUN_UP && up) || (mode == MODE_RUN_DN && dn)) begin
					prev_nxt = value;
				end else begin
					tags[0].kind = KIND_DASH;
					raw[0]       = prev;
					n            = 2'd1;
					plain        = 1'b1;
				end
			end
			default: begin
				tags[0].kind = KIND_FIRST;
				raw[0]       = value;
				n            = 2'd1;
				mode_nxt     = MODE_PLAIN;
				prev_nxt     = value;
			end
		endcase

		if (plain) begin
			prev_nxt = value;
			if (up) begin
				mode_nxt = MODE_PEND_UP;
			end else if (dn) begin
				mode_nxt = MODE_PEND_DN;
			end else begin
				tags[n[0]].kind = KIND_COMMA;
				raw[n[0]]       = value;
				n               = n + 2'd1;
				mode_nxt        = MODE_PLAIN;
			end
		end

		// flush whatever is held at end of list
		if (last_item) begin
			if (mode_nxt inside {MODE_PEND_UP, MODE_PEND_DN}) begin
				tags[n[0]].kind = KIND_COMMA;
				raw[n[0]]       = prev_nxt;
				n               = n + 2'd1;
			end else if (mode_nxt inside {MODE_RUN_UP, MODE_RUN_DN}) begin
				tags[n[0]].kind = KIND_DASH;
				raw[n[0]]       = prev_nxt;
				n               = n + 2'd1;
			end
			if (n != 2'd0) begin
				idx                    = n - 2'd1;
				tags[idx[0]].list_end = 1'b1;
			end
			mode_nxt = MODE_IDLE;
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			nums[i] = {1'b0, raw[i]} + {{W{1'b0}}, add_one};
		end
	end

	assign count = n;

endmodule

FILE: rtl/nrle_obuf.sv
// Two-slot result register that hands tokens out one beat at a time while token_ready is high.
module nrle_obuf import nrle_pkg::*; #(
	parameter int W = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic [1:0]      load_count,
	input  tag_t [1:0]      load_tags,
	input  logic [1:0][W:0] load_nums,
	output logic            free,
	output logic            token_valid,
	input  logic            token_ready,
	output tag_t            head_tag,
	output logic [W:0]      head_num
);

	logic [1:0]      cnt_q;
	tag_t [1:0]      tag_q;
	logic [1:0][W:0] num_q;
	logic            pop;

	assign token_valid = cnt_q != 2'd0;
	assign pop         = token_valid && token_ready;
	assign free        = (cnt_q == 2'd0) || (cnt_q == 2'd1 && token_ready);
	assign head_tag    = tag_q[0];
	assign head_num    = num_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tag_q <= load_tags;
			num_q <= load_nums;
		end else if (pop) begin
			tag_q[0] <= tag_q[1];
			num_q[0] <= num_q[1];
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result count out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result register loaded while busy");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !tag_q[0].list_end)
		else $error("list end ahead of another token");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cnt_q == 2'd2 && !load) |=> cnt_q == 2'd1)
		else $error("second token lost");

endmodule
